// ===== hw/rtl/nsbl_pkg.sv =====
package nsbl_pkg;

    // fixed field widths
    localparam int CODE_W  = 32;
    localparam int LABEL_W = 35;
    localparam int CNT_W   = 5;

    // configuration port
    localparam int APB_DW = 32;
    localparam int ADDR_W = 3;

    // largest n-mer the datapath can hold
    localparam int HARD_LIMIT      = 16;
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int COUNT_RESET     = 16;

    // register indexes (paddr[ADDR_W-1:2])
    localparam logic [ADDR_W-3:0] REG_SYMBOL_COUNT = 1'b0;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // per-position result handed from a lane to the output stage
    typedef struct packed {
        label_t off;   // label minus the term sum
        logic   nz;    // symbol is nonzero
        logic   act;   // position is inside the n-mer
    } lane_res_t;

endpackage

// ===== hw/rtl/nsbl_ifs.sv =====
interface nsbl_in_if
    import nsbl_pkg::*;
();
    logic  valid;
    logic  ready;
    code_t nmer_code;

    modport source (output valid, output nmer_code, input ready);
    modport sink (input valid, input nmer_code, output ready);
endinterface

interface nsbl_out_if
    import nsbl_pkg::*;
();
    logic   valid;
    logic   ready;
    label_t bucket_label;
    logic   last_label;

    modport source (output valid, output bucket_label, output last_label, input ready);
    modport sink (input valid, input bucket_label, input last_label, output ready);
endinterface

// ===== hw/rtl/nmer_sensitive_bucket_labels.sv =====
// nmer_sensitive_bucket_labels
//
// nmer_in carries one n-mer per beat (nmer_code, two bits per symbol, first
// symbol in the top used bits); label_out returns its n bucket labels, one
// per beat, labels of nonzero symbols first, last_label set on the n-th.
// n comes from the symbol_count register (APB, index 0 at address 0),
// clamped to 1..min(MAX_SYMBOLS,16); write it only while the block is idle.
//
// One lane per symbol position computes suffix, zero count and term; a
// registered adder tree sums the terms. An accepted n-mer passes lane
// stages a, b and c and is then loaded into the output buffer, which
// offers its first label. The single output channel paces the n-mers;
// the next n-mer moves into the output buffer in the cycle its
// predecessor's last label is taken, and up to three more wait in the
// lane pipeline.
//
// Reset empties the pipeline and output buffer and sets symbol_count to 16.
// While label_out is stalled the labels hold, and nmer_in.ready drops while
// the n-mer in the last lane stage waits for the output buffer.
module nmer_sensitive_bucket_labels
    import nsbl_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    nsbl_in_if.sink           nmer_in,
    nsbl_out_if.source        label_out
);

    localparam int LANES = (MAX_SYMBOLS < HARD_LIMIT) ? MAX_SYMBOLS : HARD_LIMIT;

    cnt_t             symbol_count_reg;
    cnt_t             n;
    logic [5:0]       sh2;
    code_t            xm;
    code_t            y;
    logic [LANES-1:0] zflags;
    logic             adv;
    logic             take;
    logic             v_a_reg;
    logic             v_b_reg;
    logic             v_c_reg;
    label_t           terms [LANES];
    lane_res_t        lanes [LANES];
    label_t           total;
    logic             reg_hit;

    // configuration register
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_SYMBOL_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DW'(symbol_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= CNT_W'(COUNT_RESET);
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            symbol_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // effective symbol count
    always_comb
    begin
        if (symbol_count_reg == '0)
        begin
            n = CNT_W'(1);
        end
        else if (symbol_count_reg > CNT_W'(LANES))
        begin
            n = CNT_W'(LANES);
        end
        else
        begin
            n = symbol_count_reg;
        end
    end

    // masked code and code aligned with symbol 0 at the top
    assign sh2 = {n, 1'b0};
    assign xm  = nmer_in.nmer_code & ~({CODE_W{1'b1}} << sh2);
    assign y   = xm << (6'(CODE_W) - sh2);

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            zflags[i] = (CNT_W'(i) < n) && (y[CODE_W-1-2*i -: 2] == 2'b00);
        end
    end

    // pipeline advance and stage valids
    assign adv           = !v_c_reg || take;
    assign nmer_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_a_reg <= nmer_in.valid;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
        end
    end

    // one lane per symbol position
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        nsbl_lane #(
            .LANES (LANES),
            .IDX   (g)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .n      (n),
            .xm     (xm),
            .y      (y),
            .zflags (zflags),
            .term   (terms[g]),
            .res    (lanes[g])
        );
    end

    // term sum
    nsbl_sum #(
        .LANES (LANES)
    ) u_sum (
        .clk   (clk),
        .adv   (adv),
        .terms (terms),
        .total (total)
    );

    // output buffer and ordering
    nsbl_emit #(
        .LANES (LANES)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv && v_c_reg),
        .total     (total),
        .lanes     (lanes),
        .take      (take),
        .label_out (label_out)
    );

endmodule

// ===== hw/rtl/nsbl_lane.sv =====
module nsbl_lane
    import nsbl_pkg::*;
#(
    parameter int LANES = HARD_LIMIT,
    parameter int IDX   = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  cnt_t             n,
    input  code_t            xm,
    input  code_t            y,
    input  logic [LANES-1:0] zflags,
    output label_t           term,
    output lane_res_t        res
);

    localparam int ZW = $clog2(LANES + 1);

    logic [1:0]     s;
    logic           active;
    logic           nz;
    cnt_t           d;
    logic [5:0]     sh;
    label_t         place;
    label_t         cur;
    label_t         curq;
    code_t          suffix;
    logic [ZW-1:0]  zc;
    label_t         term_new;
    label_t         prod;

    label_t         term_reg;
    code_t          suf_reg;
    logic [ZW-1:0]  zc_reg;
    label_t         prod_reg;
    logic           nz_a_reg;
    logic           act_a_reg;
    label_t         off_b_reg;
    logic           nz_b_reg;
    logic           act_b_reg;
    label_t         off_c_reg;
    logic           nz_c_reg;
    logic           act_c_reg;

    // symbol, place value and suffix of this position
    always_comb
    begin
        s      = y[CODE_W-1-2*IDX -: 2];
        active = (CNT_W'(IDX) < n);
        nz     = (s != 2'b00);
        d      = n - CNT_W'(1) - CNT_W'(IDX);
        sh     = {d, 1'b0};
        place  = LABEL_W'(1) << sh;
        cur    = LABEL_W'(s) << sh;
        curq   = cur >> 2;
        suffix = xm & (CODE_W'(place) - CODE_W'(1));
    end

    // zeros seen at earlier positions
    always_comb
    begin
        zc = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (k < IDX)
            begin
                zc = zc + ZW'(zflags[k]);
            end
        end
    end

    // per-position term and zero-count correction
    always_comb
    begin
        if (!active)
        begin
            term_new = '0;
        end
        else if (nz)
        begin
            term_new = place + LABEL_W'(curq * d);
        end
        else
        begin
            term_new = LABEL_W'(suffix);
        end
        prod = LABEL_W'(cur * zc);
    end

    // stage a: products registered
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_reg <= term_new;
            suf_reg  <= suffix;
            zc_reg   <= zc;
            prod_reg <= prod;
        end
    end

    // stage b: label offset, stage c: aligned with the total sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            off_b_reg <= LABEL_W'(suf_reg) - prod_reg + LABEL_W'(zc_reg)
                         + LABEL_W'(1) - term_reg;
            off_c_reg <= off_b_reg;
        end
    end

    // flags through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_a_reg  <= 1'b0;
            act_a_reg <= 1'b0;
            nz_b_reg  <= 1'b0;
            act_b_reg <= 1'b0;
            nz_c_reg  <= 1'b0;
            act_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            nz_a_reg  <= nz & active;
            act_a_reg <= active;
            nz_b_reg  <= nz_a_reg;
            act_b_reg <= act_a_reg;
            nz_c_reg  <= nz_b_reg;
            act_c_reg <= act_b_reg;
        end
    end

    assign term = term_reg;
    assign res  = {off_c_reg, nz_c_reg, act_c_reg};

endmodule

// ===== hw/rtl/nsbl_sum.sv =====
module nsbl_sum
    import nsbl_pkg::*;
#(
    parameter int LANES = HARD_LIMIT
)
(
    input  logic   clk,
    input  logic   adv,
    input  label_t terms [LANES],
    output label_t total
);

    localparam int GROUPS = (LANES + 3) / 4;

    label_t grp_next [GROUPS];
    label_t grp_reg  [GROUPS];
    label_t total_next;
    label_t total_reg;

    // first level: sums of four lanes
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (g * 4 + j < LANES)
                begin
                    grp_next[g] = grp_next[g] + terms[g*4+j];
                end
            end
        end
    end

    // second level: sum of the groups
    always_comb
    begin
        total_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            total_next = total_next + grp_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            grp_reg   <= grp_next;
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

// ===== hw/rtl/nsbl_emit.sv =====
module nsbl_emit
    import nsbl_pkg::*;
#(
    parameter int LANES = HARD_LIMIT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  label_t            total,
    input  lane_res_t         lanes [LANES],
    output logic              take,
    nsbl_out_if.source        label_out
);

    localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;

    label_t           lab_reg [LANES];
    logic [LANES-1:0] pend_reg;
    logic [LANES-1:0] pend_next;
    logic [LANES-1:0] nz_reg;
    logic [LANES-1:0] act_mask;
    logic [LANES-1:0] nz_mask;
    logic [LANES-1:0] src;
    logic [IW-1:0]    pick;
    logic             busy;
    logic             last;
    logic             beat;

    // nonzero positions go out first, each group in position order
    always_comb
    begin
        src  = ((pend_reg & nz_reg) != '0) ? (pend_reg & nz_reg) : pend_reg;
        pick = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (src[i])
            begin
                pick = IW'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            act_mask[i] = lanes[i].act;
            nz_mask[i]  = lanes[i].nz;
        end
    end

    assign busy = (pend_reg != '0);
    assign last = ((pend_reg & (pend_reg - LANES'(1))) == '0);
    assign beat = label_out.valid & label_out.ready;
    assign take = !busy || (beat && last);

    assign label_out.valid        = busy;
    assign label_out.bucket_label = lab_reg[pick];
    assign label_out.last_label   = last;

    // pending mask update
    always_comb
    begin
        pend_next = pend_reg;
        if (beat)
        begin
            pend_next[pick] = 1'b0;
        end
        if (load)
        begin
            pend_next = act_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // final labels
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            nz_reg <= nz_mask;
            for (int i = 0; i < LANES; i++)
            begin
                lab_reg[i] <= total + lanes[i].off;
            end
        end
    end

    // a new item only replaces a finished one
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!busy || (beat && last)))
        else $error("item loaded over pending labels");

    // the last beat empties the buffer unless a new item arrives
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && last && !load) |=> !label_out.valid)
        else $error("labels left after last beat");

    // without a load no pending position reappears
    a_no_refill: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> ((pend_reg & ~$past(pend_reg)) == '0))
        else $error("pending position appeared without load");

    // each beat retires exactly one position
    a_one_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && !load) |=> ($countones(pend_reg) + 1 == $countones($past(pend_reg))))
        else $error("beat did not retire one position");

endmodule

// ===== tb/tb_top.sv =====
module tb_top
    import nsbl_pkg::*;
();

    localparam int               HALF_PERIOD = 10;
    localparam int               QUIET_LIMIT = 2000;
    localparam int               SETTLE_WAIT = 20;
    localparam int               RAND_PHASES = 8;
    localparam int               PHASE_ITEMS = 50;
    localparam logic [ADDR_W-1:0] COUNT_ADDR = {REG_SYMBOL_COUNT, 2'b00};
    localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_SYMBOL_COUNT, 2'b00};

    typedef struct packed {
        label_t label;
        logic   last;
    } label_beat_t;

    // expected bucket labels of accepted n-mers, oldest first
    class bucket_label_book;
        cnt_t        count_reg;
        label_beat_t awaited_labels[$];
        int          mismatches;
        int          nmers_seen;
        int          labels_seen;

        function new();
            count_reg   = cnt_t'(COUNT_RESET);
            mismatches  = 0;
            nmers_seen  = 0;
            labels_seen = 0;
        endfunction

        function void write_reg(logic [ADDR_W-3:0] index, logic [APB_DW-1:0] value);
            if (index == REG_SYMBOL_COUNT)
                count_reg = value[CNT_W-1:0];
        endfunction

        // symbols in use: count clamped to 1..min(MAX_SYMBOLS, HARD_LIMIT)
        function int unsigned symbols_in_use();
            int unsigned lim;
            int unsigned n;
            lim = (MAX_SYMBOLS_DEF < HARD_LIMIT) ? MAX_SYMBOLS_DEF : HARD_LIMIT;
            n = count_reg;
            if (n < 1)
                n = 1;
            if (n > lim)
                n = lim;
            return n;
        endfunction

        // work out the n labels of one accepted n-mer
        function void take_nmer(code_t code);
            int unsigned n, pos, shift, front, back, nonzero, slot;
            logic [63:0] x, rest, zcount, total, place, cur, lab;
            logic [63:0] sym[HARD_LIMIT];
            logic [63:0] suffix[HARD_LIMIT];
            logic [63:0] zeros[HARD_LIMIT];
            logic [63:0] term[HARD_LIMIT];
            label_beat_t ordered[HARD_LIMIT];
            n = symbols_in_use();
            x = 64'(code) & ((64'd1 << (2 * n)) - 64'd1);
            rest = x;
            zcount = 0;
            total = 0;
            nonzero = 0;
            // per-position suffix, zero count and term
            for (pos = 0; pos < n; pos++)
            begin
                shift = 2 * (n - 1 - pos);
                place = 64'd1 << shift;
                cur = x & (64'd3 << shift);
                sym[pos] = cur;
                zeros[pos] = zcount;
                rest = rest - cur;
                suffix[pos] = rest;
                if (cur != 0)
                begin
                    term[pos] = place + (cur >> 2) * 64'(n - pos - 1);
                    nonzero++;
                end
                else
                begin
                    term[pos] = rest;
                    zcount++;
                end
                total = total + term[pos];
            end
            // nonzero positions first, then zero positions
            front = 0;
            back = nonzero;
            for (pos = 0; pos < n; pos++)
            begin
                lab = total - term[pos] + suffix[pos] - zeros[pos] * sym[pos]
                      + 64'd1 + zeros[pos];
                if (sym[pos] != 0)
                begin
                    slot = front;
                    front++;
                end
                else
                begin
                    slot = back;
                    back++;
                end
                ordered[slot].label = lab[LABEL_W-1:0];
                ordered[slot].last = (slot == n - 1);
            end
            for (pos = 0; pos < n; pos++)
                awaited_labels.push_back(ordered[pos]);
            nmers_seen++;
        endfunction

        function void check_label(label_t label, logic last);
            label_beat_t want;
            labels_seen++;
            if (awaited_labels.size() == 0)
            begin
                $display("%0t: label %0h last %0b arrived with none expected",
                         $time, label, last);
                mismatches++;
            end
            else
            begin
                want = awaited_labels.pop_front();
                if (want.label !== label)
                begin
                    $display("%0t: bucket_label expected %0h actual %0h",
                             $time, want.label, label);
                    mismatches++;
                end
                if (want.last !== last)
                begin
                    $display("%0t: last_label expected %0b actual %0b",
                             $time, want.last, last);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    bit                idle_on;
    int                quiet_cycles;
    int                counts_used;
    bucket_label_book  book;

    nsbl_in_if  in_if ();
    nsbl_out_if out_if ();

    nmer_sensitive_bucket_labels DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .nmer_in   (in_if),
        .label_out (out_if)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // note accepted n-mers and check labels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_if.valid && in_if.ready)
            book.take_nmer(in_if.nmer_code);
        if (rst_n && out_if.valid && out_if.ready)
            book.check_label(out_if.bucket_label, out_if.last_label);
    end

    // watchdog on cycles with no beat and no register access
    always @(posedge clk)
    begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d labels still awaited",
                     $time, QUIET_LIMIT, book.awaited_labels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // label_out ready with random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_if.ready = 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_if.ready = 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
                out_if.ready = 1'b1;
        end
    end

    // apb write: setup then access, register updated at the access edge
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [APB_DW-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        book.write_reg(addr[ADDR_W-1:2], data);
        if (addr == COUNT_ADDR)
            counts_used++;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // apb read of the count register, compared with the predictor's copy
    task automatic read_count();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = COUNT_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[CNT_W-1:0] !== book.count_reg)
        begin
            $display("%0t: symbol_count read expected %0d actual %0d",
                     $time, book.count_reg, prdata[CNT_W-1:0]);
            book.mismatches++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // offer one n-mer, possibly after a short gap, and hold until taken
    task automatic send_nmer(input code_t code);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid = 1'b1;
        in_if.nmer_code = code;
        do
            @(posedge clk);
        while (!in_if.ready);
        @(negedge clk);
    endtask

    // stop sending and wait for every awaited label
    task automatic drain();
        in_if.valid = 1'b0;
        while (book.awaited_labels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // mix of dense, sparse and near-uniform n-mers
    function automatic code_t random_code();
        code_t code;
        int    k;
        case ($urandom_range(0, 3))
            0, 1: code = $urandom;
            2:
            begin
                code = '0;
                for (k = 0; k < CODE_W / 2; k++)
                    if ($urandom_range(0, 3) == 0)
                        code[2*k +: 2] = 2'($urandom_range(0, 3));
            end
            default:
            begin
                code = {(CODE_W / 2){2'($urandom_range(0, 3))}};
                k = $urandom_range(0, CODE_W / 2 - 1);
                code[2*k +: 2] = 2'($urandom_range(0, 3));
            end
        endcase
        return code;
    endfunction

    // main sequence
    initial
    begin
        int phase;
        int item;
        book = new();
        counts_used = 0;
        idle_on = 1'b1;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.nmer_code = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset count of 16: corners of the symbol mix
        read_count();
        send_nmer(32'h0000_0000);
        send_nmer(32'hFFFF_FFFF);
        send_nmer(32'h5555_5555);
        send_nmer(32'hAAAA_AAAA);
        send_nmer(32'h0000_0003);
        send_nmer(32'hC000_0000);
        send_nmer(32'h1B1B_1B1B);
        drain();

        // write to an unused register index changes nothing
        write_reg(SPARE_ADDR, 32'd5);
        read_count();
        send_nmer(32'h1234_5678);
        drain();

        // single symbol, high bits ignored
        write_reg(COUNT_ADDR, 32'd1);
        read_count();
        send_nmer(32'h0000_0000);
        send_nmer(32'h0000_0001);
        send_nmer(32'h0000_0002);
        send_nmer(32'h0000_0003);
        send_nmer(32'hFFFF_FFFC);
        drain();

        // count of zero acts as one
        write_reg(COUNT_ADDR, 32'd0);
        read_count();
        send_nmer(32'h0000_0002);
        send_nmer(32'hFFFF_FFFE);
        drain();

        // count above the limit acts as the limit, upper data bits dropped
        write_reg(COUNT_ADDR, 32'hFFFF_FFFF);
        read_count();
        send_nmer(32'hFFFF_FFFF);
        send_nmer(32'h0000_0000);
        drain();

        // two symbols
        write_reg(COUNT_ADDR, 32'd2);
        send_nmer(32'h0000_000F);
        send_nmer(32'h0000_0004);
        send_nmer(32'h0000_0003);
        send_nmer(32'hFFFF_FFF0);
        drain();

        // random phases, each with its own count; phase 2 and the last one without idling
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            case (phase)
                0: write_reg(COUNT_ADDR, 32'd16);
                1: write_reg(COUNT_ADDR, 32'd1);
                default: write_reg(COUNT_ADDR, $urandom_range(0, 31));
            endcase
            idle_on = (phase != 2) && (phase != RAND_PHASES - 1);
            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                send_nmer(random_code());
                // hold off once mid-phase until every label is back
                if (phase == 3 && item == PHASE_ITEMS / 2)
                    drain();
            end
            drain();
        end

        // let any straggler show up
        repeat (SETTLE_WAIT) @(negedge clk);

        $display("run covered %0d n-mers, %0d labels, %0d count register writes",
                 book.nmers_seen, book.labels_seen, counts_used);
        $display("including zero and over-limit counts and an unused register write");
        if (book.mismatches == 0 && book.awaited_labels.size() == 0)
            $display("== PASS ==");
        else
        begin
            if (book.awaited_labels.size() != 0)
                $display("%0t: %0d labels never arrived", $time,
                         book.awaited_labels.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
